### design/b2s_pkg.sv
// blake2s engine shared constants, tables and helper functions
package b2s_pkg;

  localparam int unsigned DlenW = 6;
  localparam int unsigned Rounds = 10;
  localparam logic [31:0] ParamBase = 32'h0101_0000;

  function automatic logic [31:0] iv_word(input logic [2:0] idx);
    logic [31:0] w;
    case (idx)
      3'd0: w = 32'h6A09E667;
      3'd1: w = 32'hBB67AE85;
      3'd2: w = 32'h3C6EF372;
      3'd3: w = 32'hA54FF53A;
      3'd4: w = 32'h510E527F;
      3'd5: w = 32'h9B05688C;
      3'd6: w = 32'h1F83D9AB;
      3'd7: w = 32'h5BE0CD19;
      default: w = 32'h0;
    endcase
    return w;
  endfunction

  // message schedule, one nibble per entry, 16 entries per round, entry 0 in the low bits
  function automatic logic [3:0] sigma(input logic [3:0] rnd, input logic [3:0] pos);
    logic [63:0] row;
    case (rnd)
      4'd0: row = 64'hFEDCBA9876543210;
      4'd1: row = 64'h357B20C16DF984AE;
      4'd2: row = 64'h491763EADF250C8B;
      4'd3: row = 64'h8F04A562EBCD1397;
      4'd4: row = 64'hD386CB1EFA427509;
      4'd5: row = 64'h91EF57D438B0A6C2;
      4'd6: row = 64'hB8293670A4DEF15C;
      4'd7: row = 64'hA2684F05931CE7BD;
      4'd8: row = 64'h5A417D2C803B9EF6;
      4'd9: row = 64'h0DC3E9BF5167482A;
      default: row = 64'h0;
    endcase
    return row[pos*4 +: 4];
  endfunction

  function automatic logic [5:0] eff_len(input logic [5:0] v);
    logic [5:0] n;
    if (v == 6'd0) n = 6'd1;
    else if (v > 6'd32) n = 6'd32;
    else n = v;
    return n;
  endfunction

  function automatic logic [31:0] rotr(input logic [31:0] x, input logic [4:0] n);
    return (x >> n) | (x << (6'd32 - {1'b0, n}));
  endfunction

endpackage

### design/b2s_gunit.sv
// one half G step: add, xor, rotate on the four working words
module b2s_gunit (
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  input  logic [31:0] c_i,
  input  logic [31:0] d_i,
  input  logic [31:0] m_i,
  input  logic        second_i,
  output logic [31:0] a_o,
  output logic [31:0] b_o,
  output logic [31:0] c_o,
  output logic [31:0] d_o
);
  logic [4:0] r1, r2;
  always_comb begin
    r1  = second_i ? 5'd8 : 5'd16;
    r2  = second_i ? 5'd7 : 5'd12;
    a_o = a_i + b_i + m_i;
    d_o = b2s_pkg::rotr(d_i ^ a_o, r1);
    c_o = c_i + d_o;
    b_o = b2s_pkg::rotr(b_i ^ c_o, r2);
  end
endmodule

### design/blake2s_hash_engine.sv
// Unkeyed BLAKE2s engine, one message byte per input beat, digest bytes out.
// Bytes are written into a 16-word message memory (registered read). When a
// byte beat starts a new block after a full one, the full block is first
// compressed: an init state, a read state, 160 half-G steps on one shared G
// unit (each reading one message word from the memory) and a finalize state;
// the input is not ready until that is done. The closing beat zero-pads the
// rest of the block word by word, compresses with the final flag and then
// streams as many bytes as the clamped digest length (1 to 32), one per
// cycle while the sink is ready.
// A write to the configuration register restarts the engine.
module blake2s_hash_engine (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // data_byte[7:0]
  input  logic       s_axis_tuser,   // has_byte
  input  logic       s_axis_tlast,
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // digest_byte[7:0]
  output logic       m_axis_tlast,
  input  logic       cfg_we_i,
  input  logic [5:0] cfg_wdata_i
);
  typedef enum logic [2:0] {S_IDLE, S_PAD, S_INIT, S_RD, S_G, S_FIN, S_OUT} state_e;
  localparam int unsigned RndW = $clog2(b2s_pkg::Rounds + 1);

  state_e       state_q;
  logic [5:0]   dlen_q;
  logic [31:0]  h_q [8];
  logic [31:0]  v_q [16];
  logic [63:0]  cnt_q;
  logic [6:0]   nbuf_q;
  logic         final_q, pend_q;
  logic [7:0]   pend_byte_q;
  logic [RndW-1:0] rnd_q;
  logic [3:0]   step_q;     // 8 mixes x 2 halves
  logic [5:0]   oidx_q;
  logic [31:0]  mem [16];
  logic [31:0]  mrd_q;
  logic [3:0]   pad_q;

  logic [3:0] mix;
  logic [3:0] ia, ib, ic, id;
  logic [31:0] ga, gb, gc, gd;
  logic [3:0] rd_idx;
  logic [3:0] rnd_mod;

  logic in_fire;
  assign s_axis_tready = (state_q == S_IDLE);
  assign in_fire = s_axis_tvalid && s_axis_tready;

  always_comb begin
    mix = {1'b0, step_q[3:1]};
    if (mix < 4'd4) begin
      ia = mix; ib = mix + 4'd4; ic = mix + 4'd8; id = mix + 4'd12;
    end else begin
      ia = mix - 4'd4;
      ib = {2'b01, mix[1:0] + 2'd1};
      ic = {2'b10, mix[1:0] + 2'd2};
      id = {2'b11, mix[1:0] + 2'd3};
    end
    rnd_mod = 4'(rnd_q);
    rd_idx  = b2s_pkg::sigma(rnd_mod, step_q);
  end

  b2s_gunit u_g (
    .a_i(v_q[ia]), .b_i(v_q[ib]), .c_i(v_q[ic]), .d_i(v_q[id]),
    .m_i(mrd_q), .second_i(step_q[0]),
    .a_o(ga), .b_o(gb), .c_o(gc), .d_o(gd)
  );

  // next step's schedule index, read during the current step
  logic [3:0] nxt_step;
  logic [RndW-1:0] nxt_rnd;
  logic [3:0] nxt_idx;
  always_comb begin
    nxt_step = step_q + 4'd1;
    nxt_rnd  = (step_q == 4'd15) ? rnd_q + RndW'(1) : rnd_q;
    nxt_idx  = b2s_pkg::sigma(4'(nxt_rnd), nxt_step);
  end

  // message memory: byte-enabled writes, one word read per cycle
  logic       mwe;
  logic [3:0] maddr;
  logic [31:0] mwdata;
  logic [3:0]  mbe;
  logic [3:0]  raddr;
  always_comb begin
    mwe = 1'b0; maddr = nbuf_q[5:2]; mwdata = {4{s_axis_tdata}};
    mbe = 4'b0001 << nbuf_q[1:0];
    if (state_q == S_PAD) begin
      mwe = 1'b1; maddr = pad_q; mwdata = '0;
      mbe = 4'b0000;
      for (int k = 0; k < 4; k++) if ({pad_q, 2'(k)} >= nbuf_q[5:0] && !nbuf_q[6]) mbe[k] = 1'b1;
    end else if (state_q == S_INIT && pend_q) begin
      mwe = 1'b0;
    end else if (state_q == S_IDLE && in_fire && s_axis_tuser && !nbuf_q[6]) begin
      mwe = 1'b1;
    end
    raddr = (state_q == S_G) ? nxt_idx : rd_idx;
  end

  always_ff @(posedge clk_i) begin
    if (mwe) begin
      for (int k = 0; k < 4; k++) if (mbe[k]) mem[maddr][k*8 +: 8] <= mwdata[k*8 +: 8];
    end else if (state_q == S_FIN && pend_q) begin
      mem[0] <= {24'h0, pend_byte_q};
    end
    mrd_q <= mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; dlen_q <= 6'd32; cnt_q <= '0; nbuf_q <= '0;
      final_q <= 1'b0; pend_q <= 1'b0; rnd_q <= '0; step_q <= '0; oidx_q <= '0;
      pad_q <= '0;
      for (int i = 1; i < 8; i++) h_q[i] <= b2s_pkg::iv_word(3'(i));
      h_q[0] <= b2s_pkg::iv_word(3'd0) ^ b2s_pkg::ParamBase ^ 32'd32;
    end else if (cfg_we_i) begin
      dlen_q <= cfg_wdata_i; state_q <= S_IDLE; cnt_q <= '0; nbuf_q <= '0; pend_q <= 1'b0;
      for (int i = 1; i < 8; i++) h_q[i] <= b2s_pkg::iv_word(3'(i));
      h_q[0] <= b2s_pkg::iv_word(3'd0) ^ b2s_pkg::ParamBase ^
                {26'h0, b2s_pkg::eff_len(cfg_wdata_i)};
    end else begin
      case (state_q)
        S_IDLE: if (in_fire) begin
          if (s_axis_tuser && nbuf_q[6]) begin
            // full block waits: compress it, then take the byte
            pend_q <= 1'b1; pend_byte_q <= s_axis_tdata;
            final_q <= 1'b0; cnt_q <= cnt_q + 64'd64;
            state_q <= S_INIT;
            pad_q <= {3'd0, s_axis_tlast};
          end else begin
            if (s_axis_tuser) nbuf_q <= nbuf_q + 7'd1;
            if (s_axis_tlast) begin
              pad_q <= '0; final_q <= 1'b1; state_q <= S_PAD;
            end
          end
        end
        S_PAD: begin
          pad_q <= pad_q + 4'd1;
          if (pad_q == 4'd15) begin
            cnt_q <= cnt_q + {57'd0, nbuf_q};
            state_q <= S_INIT;
          end
        end
        S_INIT: begin
          for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
          for (int i = 0; i < 4; i++) v_q[i+8] <= b2s_pkg::iv_word(3'(i));
          v_q[12] <= b2s_pkg::iv_word(3'd4) ^ cnt_q[31:0];
          v_q[13] <= b2s_pkg::iv_word(3'd5) ^ cnt_q[63:32];
          v_q[14] <= b2s_pkg::iv_word(3'd6) ^ {32{final_q}};
          v_q[15] <= b2s_pkg::iv_word(3'd7);
          rnd_q <= '0; step_q <= '0;
          state_q <= S_RD;
        end
        S_RD: state_q <= S_G;
        S_G: begin
          v_q[ia] <= ga; v_q[ib] <= gb; v_q[ic] <= gc; v_q[id] <= gd;
          step_q <= nxt_step; rnd_q <= nxt_rnd;
          if (step_q == 4'd15 && rnd_q == RndW'(b2s_pkg::Rounds - 1)) state_q <= S_FIN;
        end
        S_FIN: begin
          for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] ^ v_q[i] ^ v_q[i+8];
          if (final_q) begin
            oidx_q <= '0; state_q <= S_OUT;
          end else begin
            // pending byte goes to slot 0, other words are stale but rewritten/padded later
            nbuf_q <= 7'd1; pend_q <= 1'b0;
            if (pad_q[0]) begin
              final_q <= 1'b1; pad_q <= '0; state_q <= S_PAD;
            end else state_q <= S_IDLE;
          end
        end
        S_OUT: if (m_axis_tready) begin
          oidx_q <= oidx_q + 6'd1;
          if (oidx_q + 6'd1 == b2s_pkg::eff_len(dlen_q)) begin
            state_q <= S_IDLE; cnt_q <= '0; nbuf_q <= '0; final_q <= 1'b0;
            for (int i = 1; i < 8; i++) h_q[i] <= b2s_pkg::iv_word(3'(i));
            h_q[0] <= b2s_pkg::iv_word(3'd0) ^ b2s_pkg::ParamBase ^
                      {26'h0, b2s_pkg::eff_len(dlen_q)};
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  logic [31:0] ow;
  assign ow = h_q[oidx_q[4:2]];
  assign m_axis_tvalid = (state_q == S_OUT);
  assign m_axis_tdata  = ow[oidx_q[1:0]*8 +: 8];
  assign m_axis_tlast  = (oidx_q + 6'd1 == b2s_pkg::eff_len(dlen_q));

  a_rdy_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !m_axis_tvalid) else $error("input ready during output");
  a_nbuf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nbuf_q <= 7'd64) else $error("buffer count overflow");
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && m_axis_tlast && !cfg_we_i) |=> s_axis_tready)
    else $error("no return to idle after last");
endmodule

### test/tb_top.sv
// testbench for the blake2s hash engine: byte streams in, checked digest bytes out
`timescale 1ns / 1ps

module tb_top;

  typedef struct packed {
    logic [7:0] digest_byte;
    logic       last_byte;
  } digest_beat_t;

  localparam logic [31:0] IvTab [8] = '{
    32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
    32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
  };
  localparam logic [63:0] SigmaTab [10] = '{
    64'hFEDCBA9876543210, 64'h357B20C16DF984AE, 64'h491763EADF250C8B,
    64'h8F04A562EBCD1397, 64'hD386CB1EFA427509, 64'h91EF57D438B0A6C2,
    64'hB8293670A4DEF15C, 64'hA2684F05931CE7BD, 64'h5A417D2C803B9EF6,
    64'h0DC3E9BF5167482A
  };
  localparam int unsigned CycleLimit = 2000000;

  logic       clk_i;
  logic       rst_ni;
  logic       s_tvalid, s_tready;
  logic [7:0] s_tdata;
  logic       s_tuser;
  logic       s_tlast;
  logic       m_tvalid, m_tready;
  logic [7:0] m_tdata;
  logic       m_tlast;
  logic       cfg_we;
  logic [5:0] cfg_wdata;

  blake2s_hash_engine uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),   // data_byte[7:0]
    .s_axis_tuser  (s_tuser),   // has_byte
    .s_axis_tlast  (s_tlast),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),   // digest_byte[7:0]
    .m_axis_tlast  (m_tlast),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata)
  );

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  // predictor state
  logic [5:0]  dlen_reg;
  logic [31:0] h_words [8];
  logic [63:0] msg_count;
  logic [7:0]  blk_bytes [64];
  int unsigned blk_fill;

  digest_beat_t digest_q [$];
  int unsigned  mismatches;
  int unsigned  digests_seen;
  int unsigned  msgs_sent;
  int unsigned  cycles;
  int unsigned  burst_left;
  int unsigned  stall_mode;

  function automatic logic [5:0] clamp_len(input logic [5:0] v);
    if (v == 6'd0) return 6'd1;
    if (v > 6'd32) return 6'd32;
    return v;
  endfunction

  function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  task automatic restart_hash();
    for (int i = 0; i < 8; i++) h_words[i] = IvTab[i];
    h_words[0] ^= b2s_pkg::ParamBase ^ {26'd0, clamp_len(dlen_reg)};
    msg_count = '0;
    for (int i = 0; i < 64; i++) blk_bytes[i] = 8'h00;
    blk_fill = 0;
  endtask

  task automatic compress_block(input bit is_final);
    logic [31:0] m [16];
    logic [31:0] v [16];
    int a, b, c, d, x, y;
    int unsigned sel [8][4];
    sel = '{'{0, 4, 8, 12}, '{1, 5, 9, 13}, '{2, 6, 10, 14}, '{3, 7, 11, 15},
            '{0, 5, 10, 15}, '{1, 6, 11, 12}, '{2, 7, 8, 13}, '{3, 4, 9, 14}};
    for (int i = 0; i < 16; i++)
      m[i] = {blk_bytes[4*i+3], blk_bytes[4*i+2], blk_bytes[4*i+1], blk_bytes[4*i]};
    for (int i = 0; i < 8; i++) begin
      v[i] = h_words[i];
      v[i+8] = IvTab[i];
    end
    v[12] ^= msg_count[31:0];
    v[13] ^= msg_count[63:32];
    if (is_final) v[14] = ~v[14];
    for (int r = 0; r < 10; r++) begin
      for (int g = 0; g < 8; g++) begin
        a = sel[g][0]; b = sel[g][1]; c = sel[g][2]; d = sel[g][3];
        x = SigmaTab[r][8*g +: 4];
        y = SigmaTab[r][8*g+4 +: 4];
        v[a] = v[a] + v[b] + m[x];
        v[d] = ror32(v[d] ^ v[a], 16);
        v[c] = v[c] + v[d];
        v[b] = ror32(v[b] ^ v[c], 12);
        v[a] = v[a] + v[b] + m[y];
        v[d] = ror32(v[d] ^ v[a], 8);
        v[c] = v[c] + v[d];
        v[b] = ror32(v[b] ^ v[c], 7);
      end
    end
    for (int i = 0; i < 8; i++) h_words[i] ^= v[i] ^ v[i+8];
  endtask

  task automatic absorb_item(input logic [7:0] data, input bit has_b, input bit eom);
    int unsigned n;
    digest_beat_t e;
    if (has_b) begin
      if (blk_fill == 64) begin
        msg_count += 64;
        compress_block(1'b0);
        blk_fill = 0;
      end
      blk_bytes[blk_fill] = data;
      blk_fill++;
    end
    if (eom) begin
      msg_count += blk_fill;
      for (int i = blk_fill; i < 64; i++) blk_bytes[i] = 8'h00;
      compress_block(1'b1);
      n = clamp_len(dlen_reg);
      for (int i = 0; i < n; i++) begin
        e.digest_byte = h_words[i/4][8*(i%4) +: 8];
        e.last_byte   = (i + 1 == n);
        digest_q.push_back(e);
      end
      msgs_sent++;
      restart_hash();
    end
  endtask

  // one beat to the engine, with bursty gaps
  task automatic send_item(input logic [7:0] data, input bit has_b, input bit eom);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= data;
    s_tuser  <= has_b;
    s_tlast  <= eom;
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    absorb_item(data, has_b, eom);
    @(negedge clk_i);
  endtask

  task automatic drain_and_settle();
    s_tvalid <= 1'b0;
    while (digest_q.size() != 0) @(negedge clk_i);
    repeat (400) @(negedge clk_i);
  endtask

  task automatic write_length(input logic [5:0] v);
    drain_and_settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk_i);
    cfg_we    <= 1'b0;
    dlen_reg = v;
    restart_hash();
  endtask

  task automatic send_message(input int unsigned len, input bit eom_with_byte);
    for (int i = 0; i < len; i++)
      send_item(8'($urandom), 1'b1, eom_with_byte && (i + 1 == len));
    if (!eom_with_byte || len == 0) send_item(8'($urandom), 1'b0, 1'b1);
  endtask

  task automatic test_directed();
    send_item(8'h00, 1'b0, 1'b1);            // empty message
    send_item(8'h00, 1'b1, 1'b1);
    send_item(8'hFF, 1'b1, 1'b1);
    send_item(8'hA5, 1'b0, 1'b0);            // idle beat, no result
    send_item(8'h5A, 1'b1, 1'b0);
    send_item(8'h3C, 1'b0, 1'b0);
    send_item(8'hC3, 1'b1, 1'b1);
    send_message(64, 1'b1);                  // exactly one full block
    send_message(64, 1'b0);
  endtask

  task automatic test_lengths();
    logic [5:0] lens [6] = '{6'd1, 6'd0, 6'd33, 6'd63, 6'd17, 6'd32};
    foreach (lens[k]) begin
      write_length(lens[k]);
      send_message($urandom_range(0, 3), $urandom_range(0, 1));
    end
    // restart drops a partial message
    send_item(8'h77, 1'b1, 1'b0);
    write_length(6'd32);
  endtask

  task automatic test_random();
    int unsigned len;
    int unsigned sent;
    sent = 0;
    while (sent < 55) begin
      if ($urandom_range(0, 7) == 0) begin
        send_item(8'($urandom), 1'b0, 1'b0);
        continue;
      end
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(63, 130) : $urandom_range(0, 20);
      send_message(len, $urandom_range(0, 1));
      sent += len + 1;
      if ($urandom_range(0, 5) == 0) write_length(6'($urandom_range(0, 63)));
    end
  endtask

  // receiver stall pattern
  always @(negedge clk_i) begin
    if (cycles % 97 == 0) stall_mode <= $urandom_range(0, 2);
    case (stall_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= ($urandom_range(0, 3) != 0);
      default: m_tready <= (cycles % 5 < 2);
    endcase
  end

  always @(posedge clk_i) begin
    digest_beat_t want;
    cycles <= cycles + 1;
    if (rst_ni && m_tvalid && m_tready) begin
      digests_seen <= digests_seen + 1;
      if (digest_q.size() == 0) begin
        mismatches = mismatches + 1;
        if (mismatches <= 10) $display("unexpected digest beat %h last %b", m_tdata, m_tlast);
      end else begin
        want = digest_q.pop_front();
        if (m_tdata !== want.digest_byte || m_tlast !== want.last_byte) begin
          mismatches = mismatches + 1;
          if (mismatches <= 10)
            $display("digest beat mismatch: exp %h/%b got %h/%b",
                     want.digest_byte, want.last_byte, m_tdata, m_tlast);
        end
      end
    end
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    rst_ni = 1'b0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = 1'b0;
    s_tlast = 1'b0;
    m_tready = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    stall_mode = 0;
    cycles = 0;
    mismatches = 0;
    digests_seen = 0;
    msgs_sent = 0;
    burst_left = 0;
    dlen_reg = 6'd32;
    restart_hash();
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    test_lengths();
    test_random();
    drain_and_settle();
    if (digest_q.size() != 0) mismatches++;
    $display("hashed %0d messages, checked %0d digest beats", msgs_sent, digests_seen);
    $display("lengths 0..63 exercised incl. clamping, block-boundary and empty messages");
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### files.f
design/b2s_pkg.sv
design/b2s_gunit.sv
design/blake2s_hash_engine.sv
test/tb_top.sv
